[hw/rtl/m2q_pkg.sv]
`default_nettype none
package m2q_pkg;
    localparam int FracBits = 14;
    localparam int DataW    = 16;
    localparam int TolW     = 15;
    // T range: trace branch up to 3*32767+one, pivot up to 3*32768+one
    localparam int TW       = 18;
    localparam int RadW     = TW + FracBits;        // radicand width
    localparam int RootW    = (RadW + 1) / 2;       // root width
    localparam int NumW     = 18;                   // |n| up to 65536
    localparam int DvdW     = NumW + FracBits + 1;  // dividend width
    localparam int QW       = DvdW;                 // quotient width
    localparam int TOLRESET = 2;

    typedef logic signed [DataW-1:0] t_sample;

    // flags carried through the divider lanes
    typedef struct packed {
        logic neg;
        logic zero_div;
    } t_lane_flags;
endpackage
`default_nettype wire

[hw/rtl/matrix_to_quaternion.sv]
`default_nettype none
// Rotation matrix (Q2.14) to quaternion (Q2.14) by Shepperd's method, fully
// pipelined: one matrix is accepted every cycle while the output is not
// stalled, and each result passes two front-end stages, a 16-stage square
// root, then 33 stages of quotient bits per component. Back-pressure
// on the output stalls the whole pipeline; nothing is lost or repeated.
// s_axis_tdata holds m_r0c0..m_r2c2 from bit 0 up, 16 bits each.
// m_axis_tdata holds quat_x, quat_y, quat_z, quat_w; m_axis_tuser is degenerate.
module matrix_to_quaternion (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [143:0]    s_axis_tdata,   // m_r0c0 .. m_r2c2
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic                 m_axis_tuser,   // degenerate
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [m2q_pkg::TolW-1:0] i_cfg_data
);
    import m2q_pkg::*;

    localparam int Latency = 2 + RootW + DvdW;
    localparam logic signed [TW-1:0] One = TW'(1) << FracBits;

    logic en;
    logic [Latency-1:0] r_vld;
    logic [TolW-1:0] r_tol;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_vld[Latency-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TolW'(TOLRESET);
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) r_tol <= i_cfg_data;
            if (en) r_vld <= {r_vld[Latency-2:0], s_axis_tvalid};
        end
    end

    // stage 1: degeneracy, branch and pivot selection
    t_sample m [9];
    always_comb begin
        for (int e = 0; e < 9; e++) m[e] = s_axis_tdata[e*16 +: 16];
    end

    logic n_deg;
    logic [2:0] n_row_small;
    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            n_row_small[rr] = 1'b1;
            for (int cc = 0; cc < 3; cc++) begin
                logic [DataW:0] a;
                a = m[rr*3+cc][DataW-1] ? (DataW+1)'(-$signed({m[rr*3+cc][DataW-1], m[rr*3+cc]}))
                                        : (DataW+1)'($signed(m[rr*3+cc]));
                if (a > (DataW+1)'(r_tol)) n_row_small[rr] = 1'b0;
            end
        end
        n_deg = |n_row_small;
    end

    logic signed [TW-1:0] d0, d1, d2, n_tr;
    logic [1:0] n_piv;
    logic n_trb;
    always_comb begin
        d0 = TW'(m[0]); d1 = TW'(m[4]); d2 = TW'(m[8]);
        n_tr = d0 + d1 + d2;
        n_trb = n_tr > 0;
        n_piv = 2'd0;
        if (d1 > d0) n_piv = 2'd1;
        if (d2 > ((n_piv == 2'd1) ? d1 : d0)) n_piv = 2'd2;
    end

    logic r1_deg, r1_trb;
    logic [1:0] r1_piv;
    t_sample r1_m [9];
    logic signed [TW-1:0] r1_tr;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_deg <= n_deg; r1_trb <= n_trb; r1_piv <= n_piv; r1_tr <= n_tr;
            for (int e = 0; e < 9; e++) r1_m[e] <= m[e];
        end
    end

    // stage 2: radicand and the three numerators
    function automatic logic signed [TW-1:0] ex(input t_sample v);
        return TW'(v);
    endfunction

    logic signed [TW-1:0] n_t, n_a, n_b, n_c;
    logic [1:0] n_ia, n_ib, n_ic; // 3 means w
    always_comb begin
        n_t = '0; n_a = '0; n_b = '0; n_c = '0;
        n_ia = 2'd0; n_ib = 2'd1; n_ic = 2'd2;
        if (r1_trb) begin
            n_t = r1_tr + One;
            n_a = ex(r1_m[5]) - ex(r1_m[7]);
            n_b = ex(r1_m[6]) - ex(r1_m[2]);
            n_c = ex(r1_m[1]) - ex(r1_m[3]);
        end else begin
            case (r1_piv)
                2'd0: begin
                    n_t = ex(r1_m[0]) - ex(r1_m[4]) - ex(r1_m[8]) + One;
                    n_a = ex(r1_m[5]) - ex(r1_m[7]); n_ia = 2'd3;
                    n_b = ex(r1_m[1]) + ex(r1_m[3]); n_ib = 2'd1;
                    n_c = ex(r1_m[2]) + ex(r1_m[6]); n_ic = 2'd2;
                end
                2'd1: begin
                    n_t = ex(r1_m[4]) - ex(r1_m[8]) - ex(r1_m[0]) + One;
                    n_a = ex(r1_m[6]) - ex(r1_m[2]); n_ia = 2'd3;
                    n_b = ex(r1_m[5]) + ex(r1_m[7]); n_ib = 2'd2;
                    n_c = ex(r1_m[3]) + ex(r1_m[1]); n_ic = 2'd0;
                end
                default: begin
                    n_t = ex(r1_m[8]) - ex(r1_m[0]) - ex(r1_m[4]) + One;
                    n_a = ex(r1_m[1]) - ex(r1_m[3]); n_ia = 2'd3;
                    n_b = ex(r1_m[6]) + ex(r1_m[2]); n_ib = 2'd0;
                    n_c = ex(r1_m[7]) + ex(r1_m[5]); n_ic = 2'd1;
                end
            endcase
            if (n_t < 0) n_t = '0;
        end
    end

    // square root pipeline, one result bit per stage
    localparam int SqS = RootW;
    logic [RadW-1:0]  s_x   [SqS+1];
    logic [RadW+1:0]  s_rem [SqS+1];
    logic [RootW-1:0] s_r   [SqS+1];
    logic signed [TW-1:0] s_a [SqS+1], s_b [SqS+1], s_c [SqS+1];
    logic [1:0] s_ia [SqS+1], s_ib [SqS+1], s_ic [SqS+1];
    logic s_deg [SqS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            s_x[0] <= RadW'(n_t) << FracBits;
            s_rem[0] <= '0; s_r[0] <= '0;
            s_a[0] <= n_a; s_b[0] <= n_b; s_c[0] <= n_c;
            s_ia[0] <= n_ia; s_ib[0] <= n_ib; s_ic[0] <= n_ic;
            s_deg[0] <= r1_deg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < SqS; g++) begin : g_sqrt
            logic [RadW+1:0] n_rm, n_tt;
            logic [RootW-1:0] n_rr;
            always_comb begin
                n_rm = {s_rem[g][RadW-1:0], s_x[g][RadW-1 -: 2]};
                n_tt = {(RadW+2-RootW-2)'(0), s_r[g], 2'b01};
                if (n_rm >= n_tt) begin
                    n_rm = n_rm - n_tt;
                    n_rr = {s_r[g][RootW-2:0], 1'b1};
                end else begin
                    n_rr = {s_r[g][RootW-2:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    s_rem[g+1] <= n_rm; s_r[g+1] <= n_rr;
                    s_x[g+1] <= s_x[g] << 2;
                    s_a[g+1] <= s_a[g]; s_b[g+1] <= s_b[g]; s_c[g+1] <= s_c[g];
                    s_ia[g+1] <= s_ia[g]; s_ib[g+1] <= s_ib[g]; s_ic[g+1] <= s_ic[g];
                    s_deg[g+1] <= s_deg[g];
                end
            end
        end
    endgenerate

    // rounding: remainder x - r*r greater than r means round up
    logic [RootW:0] w_R;
    assign w_R = (s_rem[SqS] > (RadW+2)'(s_r[SqS])) ? (RootW+1)'(s_r[SqS]) + 1'b1
                                                    : (RootW+1)'(s_r[SqS]);

    logic [RootW:0] w_h;
    logic signed [DataW-1:0] w_half;
    assign w_h = (w_R + 1'b1) >> 1;
    assign w_half = (w_h > (RootW+1)'(32767)) ? 16'sh7fff : DataW'(w_h);

    function automatic logic [DvdW-1:0] dvd(input logic signed [TW-1:0] n,
                                             input logic [RootW:0] r);
        logic [NumW-1:0] mg;
        mg = n[TW-1] ? NumW'(-n) : NumW'(n);
        return (DvdW'(mg) << FracBits) + DvdW'(r);
    endfunction

    logic signed [DataW-1:0] q_a, q_b, q_c;
    m2q_divlane u_div_a (.i_clk, .i_en(en), .i_dvd(dvd(s_a[SqS], w_R)), .i_dvs(w_R << 1),
        .i_flags('{neg: s_a[SqS][TW-1], zero_div: w_R == '0}), .o_q(q_a));
    m2q_divlane u_div_b (.i_clk, .i_en(en), .i_dvd(dvd(s_b[SqS], w_R)), .i_dvs(w_R << 1),
        .i_flags('{neg: s_b[SqS][TW-1], zero_div: w_R == '0}), .o_q(q_b));
    m2q_divlane u_div_c (.i_clk, .i_en(en), .i_dvd(dvd(s_c[SqS], w_R)), .i_dvs(w_R << 1),
        .i_flags('{neg: s_c[SqS][TW-1], zero_div: w_R == '0}), .o_q(q_c));

    // side data delayed alongside the divider lanes
    logic signed [DataW-1:0] d_half [DvdW];
    logic [1:0] d_ia [DvdW], d_ib [DvdW], d_ic [DvdW];
    logic d_deg [DvdW];
    always_ff @(posedge i_clk) begin
        if (en) begin
            d_half[0] <= w_half; d_ia[0] <= s_ia[SqS]; d_ib[0] <= s_ib[SqS];
            d_ic[0] <= s_ic[SqS]; d_deg[0] <= s_deg[SqS];
            for (int e = 1; e < DvdW; e++) begin
                d_half[e] <= d_half[e-1]; d_ia[e] <= d_ia[e-1]; d_ib[e] <= d_ib[e-1];
                d_ic[e] <= d_ic[e-1]; d_deg[e] <= d_deg[e-1];
            end
        end
    end

    // output assembly: the slot not named by a, b or c takes the half root
    logic signed [DataW-1:0] q [4];
    always_comb begin
        for (int e = 0; e < 4; e++) q[e] = d_half[DvdW-1];
        q[d_ia[DvdW-1]] = q_a;
        q[d_ib[DvdW-1]] = q_b;
        q[d_ic[DvdW-1]] = q_c;
        if (d_deg[DvdW-1]) begin
            q[0] = '0; q[1] = '0; q[2] = '0;
            q[3] = (FracBits >= 15) ? 16'sh7fff : DataW'(One);
        end
        m_axis_tdata = {q[3], q[2], q[1], q[0]};
        m_axis_tuser = d_deg[DvdW-1];
    end
endmodule
`default_nettype wire

[hw/rtl/m2q_divlane.sv]
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, saturating output
module m2q_divlane (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [m2q_pkg::DvdW-1:0]   i_dvd,
    input  wire logic [m2q_pkg::RootW:0]    i_dvs,
    input  wire m2q_pkg::t_lane_flags       i_flags,
    output logic signed [m2q_pkg::DataW-1:0] o_q
);
    import m2q_pkg::*;

    localparam int RemW = RootW + 2;

    logic [DvdW-1:0]   r_dvd   [1:DvdW];
    logic [RemW-1:0]   r_rem   [1:DvdW];
    logic [RootW:0]    r_dvs   [1:DvdW];
    t_lane_flags       r_flg   [1:DvdW];

    genvar g;
    generate
        for (g = 0; g < DvdW; g++) begin : g_stage
            logic [DvdW-1:0] w_dvd;
            logic [RemW-1:0] w_rem;
            logic [RootW:0]  w_dvs;
            t_lane_flags     w_flg;
            logic [RemW-1:0] n_sh;
            logic [RemW-1:0] n_rem;
            logic [DvdW-1:0] n_dvd;
            if (g == 0) begin : g_src
                assign w_dvd = i_dvd;
                assign w_rem = '0;
                assign w_dvs = i_dvs;
                assign w_flg = i_flags;
            end else begin : g_src
                assign w_dvd = r_dvd[g];
                assign w_rem = r_rem[g];
                assign w_dvs = r_dvs[g];
                assign w_flg = r_flg[g];
            end
            always_comb begin
                n_sh = {w_rem[RemW-2:0], w_dvd[DvdW-1]};
                if (n_sh >= {1'b0, w_dvs}) begin
                    n_rem = n_sh - {1'b0, w_dvs};
                    n_dvd = {w_dvd[DvdW-2:0], 1'b1};
                end else begin
                    n_rem = n_sh;
                    n_dvd = {w_dvd[DvdW-2:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g+1] <= n_rem;
                    r_dvd[g+1] <= n_dvd;
                    r_dvs[g+1] <= w_dvs;
                    r_flg[g+1] <= w_flg;
                end
            end
        end
    endgenerate

    logic [QW-1:0] w_q;
    always_comb begin
        w_q = r_dvd[DvdW];
        if (r_flg[DvdW].zero_div) begin
            o_q = '0;
        end else if (r_flg[DvdW].neg) begin
            o_q = (w_q >= QW'(32768)) ? 16'sh8000 : DataW'(-$signed({1'b0, w_q}));
        end else begin
            o_q = (w_q >= QW'(32767)) ? 16'sh7fff : DataW'(w_q);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/m2q_checker.sv]
`default_nettype none
module m2q_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output side");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == 48'd0)
        else $error("degenerate result not identity");
endmodule

bind matrix_to_quaternion m2q_checker u_m2q_checker (
    .i_clk, .i_rst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import m2q_pkg::*;

    typedef struct {
        logic signed [15:0] x, y, z, w;
        logic               degen;
    } t_quat;

    typedef struct {
        logic signed [15:0] m [9];
        logic               known;
        t_quat              q;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [TolW-1:0] i_cfg_data = '0;

    matrix_to_quaternion u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    localparam longint ONE = 64'sd1 << FracBits;

    int unsigned tolerance = TOLRESET;
    t_quat       quat_queue[$];
    int          error_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_off = 1'b0;

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // nearest integer square root
    function automatic longint round_sqrt(longint x);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= x) lo = mid;
            else hi = mid - 1;
        end
        if (x - lo * lo > lo) lo++;
        return lo;
    endfunction

    function automatic longint ratio(longint n, longint r);
        longint mag, q;
        if (r == 0) return 0;
        mag = n < 0 ? -n : n;
        q = ((mag << FracBits) + r) / (2 * r);
        if (q > 65536) q = 65536;
        return clamp16(n < 0 ? -q : q);
    endfunction

    function automatic longint half_of(longint r);
        longint h;
        h = (r + 1) >>> 1;
        return h > 32767 ? 32767 : h;
    endfunction

    function automatic t_quat shepperd(logic signed [15:0] e [9], int unsigned tol);
        longint m [3][3];
        longint q [4];
        longint tr, t, rt, a;
        int     i, j, k;
        bit     all_small, degen;
        t_quat  res;
        degen = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) m[r][c] = e[r*3+c];
        for (int r = 0; r < 3; r++) begin
            all_small = 1;
            for (int c = 0; c < 3; c++) begin
                a = m[r][c] < 0 ? -m[r][c] : m[r][c];
                if (a > tol) all_small = 0;
            end
            if (all_small) degen = 1;
        end
        if (degen) begin
            q[0] = 0; q[1] = 0; q[2] = 0; q[3] = clamp16(ONE);
        end else begin
            tr = m[0][0] + m[1][1] + m[2][2];
            if (tr > 0) begin
                rt = round_sqrt((tr + ONE) << FracBits);
                q[3] = half_of(rt);
                q[0] = ratio(m[1][2] - m[2][1], rt);
                q[1] = ratio(m[2][0] - m[0][2], rt);
                q[2] = ratio(m[0][1] - m[1][0], rt);
            end else begin
                i = 0;
                if (m[1][1] > m[0][0]) i = 1;
                if (m[2][2] > m[i][i]) i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                t = m[i][i] - m[j][j] - m[k][k] + ONE;
                if (t < 0) t = 0;
                rt = round_sqrt(t << FracBits);
                q[i] = half_of(rt);
                q[3] = ratio(m[j][k] - m[k][j], rt);
                q[j] = ratio(m[i][j] + m[j][i], rt);
                q[k] = ratio(m[i][k] + m[k][i], rt);
            end
        end
        res.x = 16'(q[0]); res.y = 16'(q[1]); res.z = 16'(q[2]); res.w = 16'(q[3]);
        res.degen = degen;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic idle_burst();
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_matrix(logic signed [15:0] e [9], logic known, t_quat q);
        logic [143:0] d;
        for (int n = 0; n < 9; n++) d[n*16 +: 16] = e[n];
        idle_burst();
        quat_queue.push_back(known ? q : shepperd(e, tolerance));
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_tolerance(int unsigned v);
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_data  <= TolW'(v);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tolerance = v;
    endtask

    // results side
    initial begin
        t_quat want;
        logic signed [15:0] g;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                if (m_axis_tvalid && m_axis_tready) begin
                    if (quat_queue.size() == 0) begin
                        $display("unexpected transfer at %0t", $time);
                        error_count++;
                    end else begin
                        want = quat_queue.pop_front();
                        g = m_axis_tdata[15:0];
                        if (g !== want.x) report_mismatch("quat_x", g, want.x);
                        g = m_axis_tdata[31:16];
                        if (g !== want.y) report_mismatch("quat_y", g, want.y);
                        g = m_axis_tdata[47:32];
                        if (g !== want.z) report_mismatch("quat_z", g, want.z);
                        g = m_axis_tdata[63:48];
                        if (g !== want.w) report_mismatch("quat_w", g, want.w);
                        if (m_axis_tuser !== want.degen)
                            report_mismatch("degenerate", m_axis_tuser, want.degen);
                    end
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(int'($urandom_range(0, 8)) - 4);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // near-rotation from a random unit-ish quaternion
    function automatic void rotation(output logic signed [15:0] e [9]);
        real a, b, c, d, n;
        real r [9];
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
        a /= n; b /= n; c /= n; d /= n;
        r[0] = 1 - 2*(c*c + d*d); r[1] = 2*(b*c - a*d); r[2] = 2*(b*d + a*c);
        r[3] = 2*(b*c + a*d); r[4] = 1 - 2*(b*b + d*d); r[5] = 2*(c*d - a*b);
        r[6] = 2*(b*d - a*c); r[7] = 2*(c*d + a*b); r[8] = 1 - 2*(b*b + c*c);
        for (int n2 = 0; n2 < 9; n2++)
            e[n2] = 16'($rtoi(r[n2] * 16384.0) + int'($urandom_range(0, 6)) - 3);
    endfunction

    task automatic random_phase(int count);
        logic signed [15:0] e [9];
        t_quat dummy;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) != 0) rotation(e);
            else for (int c = 0; c < 9; c++) e[c] = rand_entry();
            if ($urandom_range(0, 15) == 0) begin
                // force a near-zero row
                int r;
                r = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++)
                    e[r*3+c] = 16'(int'($urandom_range(0, 2*tolerance)) - int'(tolerance));
            end
            send_matrix(e, 1'b0, dummy);
        end
        end_stream();
    endtask

    initial begin
        t_stim_row directed [$];
        t_stim_row row;
        t_quat idq, zq;
        idq.x = 0; idq.y = 0; idq.z = 0; idq.w = 16384; idq.degen = 1;
        zq = idq; zq.degen = 0;
        row.known = 0; row.q = zq;
        // identity: trace branch, w = 1
        row.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; row.known = 1; row.q = zq;
        directed.push_back(row);
        row.known = 0;
        // all zero: degenerate
        row.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; row.known = 1; row.q = idq;
        directed.push_back(row);
        // rows at the tolerance edge
        row.m = '{2, -2, 2, 0, 16384, 0, 0, 0, 16384}; row.known = 1; row.q = idq;
        directed.push_back(row);
        row.known = 0;
        row.m = '{3, -2, 2, 0, 16384, 0, 0, 0, 16384}; directed.push_back(row);
        row.m = '{16384, 0, 0, 0, 16384, 0, -2, 2, -2}; row.known = 1; row.q = idq;
        directed.push_back(row);
        row.known = 0;
        // pivots x, y, z (180 degree turns)
        row.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; directed.push_back(row);
        row.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; directed.push_back(row);
        row.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; directed.push_back(row);
        // diagonal ties
        row.m = '{-100, 50, 30, 20, -100, 10, 5, 7, -100}; directed.push_back(row);
        row.m = '{-200, 50, 30, 20, -100, 10, 5, 7, -100}; directed.push_back(row);
        row.m = '{0, 900, 0, 900, 0, 900, 900, 0, 0}; directed.push_back(row);
        // extremes, saturation
        row.m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        directed.push_back(row);
        row.m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  -32768};
        directed.push_back(row);
        row.m = '{-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768};
        directed.push_back(row);
        row.m = '{1, 32767, -32768, -32768, 1, 32767, 32767, -32768, -1};
        directed.push_back(row);
        row.m = '{-32768, 32767, 0, 0, 32767, -32768, 16, 0, 0}; directed.push_back(row);
        row.m = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384}; directed.push_back(row);
        row.m = '{1, 0, 0, 0, 0, -32768, 0, 32767, 0}; directed.push_back(row);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_matrix(directed[n].m, directed[n].known, directed[n].q);
        end_stream();
        random_phase(150);

        write_tolerance(0);
        random_phase(100);
        // long receiver hold-off so the pipeline fills and stalls the input
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(150);
        join
        write_tolerance(32767);
        random_phase(40);
        write_tolerance($urandom_range(1, 400));
        random_phase(150);
        write_tolerance(2);
        no_idle = 1'b1;
        random_phase(110);

        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("matrix_to_quaternion test passed");
        else
            $display("matrix_to_quaternion test failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("matrix_to_quaternion test failed");
        $finish;
    end
endmodule
`default_nettype wire

[matrix_to_quaternion.f]
hw/rtl/m2q_pkg.sv
hw/rtl/m2q_divlane.sv
hw/rtl/matrix_to_quaternion.sv
hw/rtl/m2q_checker.sv
tb/tb_top.sv
